### sv/bpu_pkg.sv
// Shared types and constants for the bitmap pixel unpacker.
// No dependencies; imported by bpu_ctl, bpu_dp, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bpu_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int DIV_STEPS     = 16;
  localparam int DIV_CW        = $clog2(DIV_STEPS);
  localparam int NCH           = 3;

  // floor(x/3) == (x * RECIP3) >> RECIP3_SH for every byte count in a row
  localparam int RECIP3        = 43691;
  localparam int RECIP3_SH     = 17;

  // register indexes
  localparam logic [2:0] CFG_BPP         = 3'd0;
  localparam logic [2:0] CFG_ROW_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_PAL_COUNT   = 3'd2;
  localparam logic [2:0] CFG_RED_MASK    = 3'd3;
  localparam logic [2:0] CFG_GREEN_MASK  = 3'd4;
  localparam logic [2:0] CFG_BLUE_MASK   = 3'd5;

  // input operations
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  // what an accepted word starts
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PAL,
    ACT_DIRECT,
    ACT_MASK
  } act_t;

  typedef struct packed {
    logic take;
    logic pal_rd;
    logic pal_load;
    logic scan;
    logic mul;
    logic chk;
    logic div;
    logic pix_load;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic col_ok;
    logic last_pix;
    logic scan_done;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    logic [11:0] column;
    logic        row_end;
    logic        run_end;
  } pix_t;

endpackage

`default_nettype wire

### sv/bpu_in_if.sv
// Input channel: valid/ready handshake with palette-write and data-byte payload.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface bpu_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;

  modport source (output valid, operation, data_byte, palette_index, palette_red,
                  palette_green, palette_blue, input ready);
  modport sink   (input valid, operation, data_byte, palette_index, palette_red,
                  palette_green, palette_blue, output ready);
endinterface

`default_nettype wire

### sv/bpu_out_if.sv
// Result channel: valid/ready handshake carrying one 16-bit RGB pixel word.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface bpu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_level;
  logic [15:0] green_level;
  logic [15:0] blue_level;
  logic [11:0] column;
  logic        row_end;
  logic        run_end;

  modport source (output valid, red_level, green_level, blue_level, column, row_end,
                  run_end, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, column, row_end,
                  run_end, output ready);
endinterface

`default_nettype wire

### sv/bpu_ctl.sv
// Sequencing state machine of the pixel unpacker: handshakes and datapath commands.
// Depends on bpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpu_ctl import bpu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PRD   = 8'b0000_0010,
    S_PEMIT = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_CHK   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (sts.act)
            ACT_PAL:    state_nxt = S_PRD;
            ACT_DIRECT: state_nxt = S_EMIT;
            ACT_MASK:   state_nxt = S_SCAN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_PRD: begin
        if (sts.col_ok) begin
          cmd.pal_rd = 1'b1;
          state_nxt  = S_PEMIT;
        end else begin
          state_nxt  = S_IDLE;
        end
      end
      S_PEMIT: begin
        if (out_free) begin
          cmd.pal_load = 1'b1;
          state_nxt    = sts.last_pix ? S_IDLE : S_PRD;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.pix_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pal_load || cmd.pix_load) out_valid_nxt = 1'b1;
    else if (out_ready)               out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/bpu_dp.sv
// Datapath of the pixel unpacker: registers, row counters, palette memory,
// mask scan lanes, restoring dividers and the output word register. Uses bpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpu_dp import bpu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [7:0]  in_palette_index,
  input  wire logic [7:0]  in_palette_red,
  input  wire logic [7:0]  in_palette_green,
  input  wire logic [7:0]  in_palette_blue,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output pix_t             out_pix
);

  // configuration
  logic [5:0]  bpp_r;
  logic [12:0] rw_r;
  logic [8:0]  pc_r;
  logic [31:0] mask_r [NCH];

  // row state
  logic [13:0] bir_r;
  logic [23:0] part_r;
  logic [1:0]  pos_r;

  // per-word work registers
  logic [7:0]  data_r;
  logic [2:0]  k_r;
  logic [16:0] base_r;
  logic [31:0] word_r;
  logic [11:0] col_r;
  logic        mode_mask_r;
  logic [23:0] rdq_r;
  pix_t        out_r;

  // mask lanes
  logic [31:0] m_r   [NCH];
  logic [31:0] v_r   [NCH];
  logic [5:0]  nb_r  [NCH];
  logic        run_r [NCH];
  logic        dn_r  [NCH];
  logic [47:0] n_r   [NCH];
  logic [31:0] mx_r  [NCH];
  logic        sat_r [NCH];
  logic [47:0] rem_r [NCH];
  logic [46:0] d_r   [NCH];
  logic [15:0] q_r   [NCH];
  logic [DIV_CW-1:0] dc_r;

  logic [23:0] pal_mem [PALETTE_DEPTH];

  // derived
  logic [12:0] width;
  logic        supported, pal_mode;
  logic [17:0] bits_total;
  logic [18:0] bits_rnd;
  logic [15:0] stride, bir_inc;
  logic        row_wrap;
  logic [2:0]  bpb;
  logic [14:0] row_bytes;
  logic        in_row, complete;
  logic [31:0] word;
  logic [30:0] prod3;
  logic [11:0] mcol;
  logic [16:0] pbase;
  act_t        act;
  logic [16:0] col_k;
  logic [17:0] col_k1;
  logic        per_last;
  logic [7:0]  idx;
  logic [8:0]  count9;
  logic        hit;
  logic [15:0] lvl [NCH];
  logic [12:0] col_r1;

  always_comb begin
    if (rw_r == '0)                     width = 13'd1;
    else if (rw_r > 13'(MAX_WIDTH))     width = 13'(MAX_WIDTH);
    else                                width = rw_r;

    supported = bpp_r inside {6'd1, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32};
    pal_mode  = (bpp_r <= 6'd8);

    case (bpp_r)
      6'd1:    bits_total = {5'b0, width};
      6'd4:    bits_total = {3'b0, width, 2'b0};
      6'd8:    bits_total = {2'b0, width, 3'b0};
      6'd16:   bits_total = {1'b0, width, 4'b0};
      6'd24:   bits_total = {1'b0, width, 4'b0} + {2'b0, width, 3'b0};
      default: bits_total = {width, 5'b0};
    endcase
    bits_rnd = {1'b0, bits_total} + 19'd31;
    stride   = {bits_rnd[18:5], 2'b00};
    bir_inc  = {2'b0, bir_r} + 16'd1;
    row_wrap = (bir_inc >= stride);

    bpb = bpp_r[5:3];
    case (bpb)
      3'd2:    row_bytes = {1'b0, width, 1'b0};
      3'd3:    row_bytes = {1'b0, width, 1'b0} + {2'b0, width};
      default: row_bytes = {width, 2'b0};
    endcase
    in_row   = ({1'b0, bir_r} < row_bytes);
    complete = ({1'b0, pos_r} >= (bpb - 3'd1));
    word     = {8'h00, part_r} | (32'(in_data_byte) << {pos_r, 3'b000});

    prod3 = 31'(bir_r) * 31'(RECIP3);
    case (bpb)
      3'd2:    mcol = bir_r[12:1];
      3'd3:    mcol = prod3[RECIP3_SH+11:RECIP3_SH];
      default: mcol = bir_r[13:2];
    endcase

    case (bpp_r)
      6'd1:    pbase = {bir_r, 3'b000};
      6'd4:    pbase = {1'b0, bir_r, 2'b00} >> 1;
      default: pbase = {3'b000, bir_r};
    endcase

    if (in_operation != OP_DATA || !supported) act = ACT_NONE;
    else if (pal_mode)                        act = ACT_PAL;
    else if (in_row && complete)              act = (bpb == 3'd3) ? ACT_DIRECT : ACT_MASK;
    else                                      act = ACT_NONE;
  end

  // palette run
  always_comb begin
    col_k  = base_r + 17'(k_r);
    col_k1 = {1'b0, col_k} + 18'd1;
    case (bpp_r)
      6'd1:    per_last = (k_r == 3'd7);
      6'd4:    per_last = (k_r == 3'd1);
      default: per_last = 1'b1;
    endcase
    case (bpp_r)
      6'd1:    idx = {7'b0, data_r[7]};
      6'd4:    idx = {4'b0, data_r[7:4]};
      default: idx = data_r;
    endcase
    if (pc_r == '0)                          count9 = 9'd1 << bpp_r;
    else if (pc_r > 9'(PALETTE_DEPTH))       count9 = 9'(PALETTE_DEPTH);
    else                                     count9 = pc_r;
    hit = ({1'b0, idx} < count9);
  end

  assign sts.act       = act;
  assign sts.col_ok    = (col_k < 17'(width));
  assign sts.last_pix  = per_last || (col_k1 >= 18'(width));
  assign sts.scan_done = dn_r[0] && dn_r[1] && dn_r[2];
  assign sts.div_done  = (dc_r == '0);
  assign out_pix       = out_r;
  assign col_r1        = {1'b0, col_r} + 13'd1;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (mx_r[i] == '0) lvl[i] = '0;
      else if (sat_r[i]) lvl[i] = 16'hFFFF;
      else               lvl[i] = q_r[i];
    end
  end

  // configuration and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r     <= 6'd24;
      rw_r      <= 13'd1;
      pc_r      <= '0;
      mask_r[0] <= 32'h00FF_0000;
      mask_r[1] <= 32'h0000_FF00;
      mask_r[2] <= 32'h0000_00FF;
      bir_r     <= '0;
      part_r    <= '0;
      pos_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BPP:        bpp_r     <= cfg_data[5:0];
          CFG_ROW_WIDTH:  rw_r      <= cfg_data[12:0];
          CFG_PAL_COUNT:  pc_r      <= cfg_data[8:0];
          CFG_RED_MASK:   mask_r[0] <= cfg_data;
          CFG_GREEN_MASK: mask_r[1] <= cfg_data;
          CFG_BLUE_MASK:  mask_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take && in_operation == OP_DATA && supported) begin
        // end of row stride clears the pixel assembly as well
        if (row_wrap) begin
          bir_r  <= '0;
          part_r <= '0;
          pos_r  <= '0;
        end else begin
          bir_r  <= bir_inc[13:0];
          if (!pal_mode && in_row) begin
            if (!complete) begin
              part_r <= word[23:0];
              pos_r  <= pos_r + 2'd1;
            end else begin
              part_r <= '0;
              pos_r  <= '0;
            end
          end
        end
      end
    end
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (cmd.take && in_operation == OP_PALETTE)
      pal_mem[in_palette_index] <= {in_palette_red, in_palette_green, in_palette_blue};
  end

  always_ff @(posedge clk) begin
    if (cmd.pal_rd) rdq_r <= pal_mem[idx];
  end

  // work registers and output word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      data_r      <= in_data_byte;
      k_r         <= '0;
      base_r      <= pbase;
      word_r      <= word;
      col_r       <= mcol;
      mode_mask_r <= (act == ACT_MASK);
    end
    if (cmd.pal_load) begin
      out_r.red_level   <= hit ? {rdq_r[23:16], rdq_r[23:16]} : '0;
      out_r.green_level <= hit ? {rdq_r[15:8], rdq_r[15:8]} : '0;
      out_r.blue_level  <= hit ? {rdq_r[7:0], rdq_r[7:0]} : '0;
      out_r.column      <= col_k[11:0];
      out_r.row_end     <= (col_k1 == 18'(width));
      out_r.run_end     <= sts.last_pix;
      k_r               <= k_r + 3'd1;
      case (bpp_r)
        6'd1:    data_r <= {data_r[6:0], 1'b0};
        6'd4:    data_r <= {data_r[3:0], 4'h0};
        default: data_r <= '0;
      endcase
    end
    if (cmd.pix_load) begin
      if (mode_mask_r) begin
        out_r.red_level   <= lvl[0];
        out_r.green_level <= lvl[1];
        out_r.blue_level  <= lvl[2];
      end else begin
        out_r.red_level   <= {word_r[23:16], word_r[23:16]};
        out_r.green_level <= {word_r[15:8], word_r[15:8]};
        out_r.blue_level  <= {word_r[7:0], word_r[7:0]};
      end
      out_r.column  <= col_r;
      out_r.row_end <= (col_r1 == width);
      out_r.run_end <= 1'b1;
    end
  end

  // mask lanes: field scan, then v*65535 + maxv/2 divided by maxv
  always_ff @(posedge clk) begin
    for (int i = 0; i < NCH; i++) begin
      if (cmd.take) begin
        m_r[i]   <= mask_r[i];
        v_r[i]   <= word & mask_r[i];
        nb_r[i]  <= '0;
        run_r[i] <= 1'b0;
        dn_r[i]  <= 1'b0;
      end else if (cmd.scan && !dn_r[i]) begin
        if (!run_r[i]) begin
          if (m_r[i] == '0) begin
            dn_r[i] <= 1'b1;
          end else if (m_r[i][0]) begin
            run_r[i] <= 1'b1;
            nb_r[i]  <= nb_r[i] + 6'd1;
            m_r[i]   <= m_r[i] >> 1;
          end else begin
            m_r[i] <= m_r[i] >> 1;
            v_r[i] <= v_r[i] >> 1;
          end
        end else if (m_r[i][0]) begin
          nb_r[i] <= nb_r[i] + 6'd1;
          m_r[i]  <= m_r[i] >> 1;
        end else begin
          dn_r[i] <= 1'b1;
        end
      end
      if (cmd.mul) begin
        mx_r[i] <= 32'((33'd1 << nb_r[i]) - 33'd1);
        n_r[i]  <= {v_r[i], 16'h0000} - {16'h0000, v_r[i]}
                   + {17'b0, 31'(((33'd1 << nb_r[i]) - 33'd1) >> 1)};
      end
      if (cmd.chk) begin
        sat_r[i] <= (n_r[i] >= {mx_r[i], 16'h0000});
        rem_r[i] <= n_r[i];
        d_r[i]   <= {mx_r[i], 15'b0};
        q_r[i]   <= '0;
      end
      if (cmd.div) begin
        if ({1'b0, d_r[i]} <= rem_r[i]) begin
          rem_r[i]     <= rem_r[i] - {1'b0, d_r[i]};
          q_r[i][dc_r] <= 1'b1;
        end
        d_r[i] <= d_r[i] >> 1;
      end
    end
    if (cmd.chk)      dc_r <= DIV_CW'(DIV_STEPS - 1);
    else if (cmd.div) dc_r <= dc_r - 1'b1;
  end

endmodule

`default_nettype wire

### sv/bitmap_pixel_unpacker.sv
// Top level of the bitmap pixel unpacker: channels, config port, controller
// and datapath. Depends on bpu_pkg, bpu_in_if, bpu_out_if, bpu_ctl, bpu_dp.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  in_bus  : one word per handshake. operation=0 writes palette entry
//            palette_index with R,G,B (no result); operation=1 delivers the
//            next byte of row data.
//  out_bus : one word per pixel, 16-bit R,G,B, column, row_end, run_end
//            (run_end marks the last pixel caused by an input word).
//  cfg_*   : write-only registers (index 0..5: bpp, row width, palette count,
//            red/green/blue masks). Write only while the block is idle.
// Sequencing
//  - Palette writes, unsupported depths, and padding or non-final bytes at
//    16/24/32 bits: done on acceptance, next word can follow immediately.
//  - 1/4/8-bit bytes: per pixel a palette RAM read, then an output load,
//    up to 8 pixels per byte; a padding byte there ends in the read state.
//  - 24-bit pixel: the final byte goes straight to the output load; the next
//    word is taken once the output register is loaded.
//  - 16/32-bit pixel: the final byte runs the bit-serial mask scan, multiply,
//    check and the 16-step divider before the output load.
//  The output register holds one finished pixel; in_ready drops while a
//  pixel run is in progress and the receiver stalls simply hold it there.
// Reset (synchronous, rst_n low): config back to 24 bpp, width 1, default
//  masks; row counters cleared. Palette RAM is not cleared.

module bitmap_pixel_unpacker import bpu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bpu_in_if.sink           in_bus,
  bpu_out_if.source        out_bus,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  pix_t pix;

  bpu_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpu_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (in_bus.operation),
    .in_data_byte     (in_bus.data_byte),
    .in_palette_index (in_bus.palette_index),
    .in_palette_red   (in_bus.palette_red),
    .in_palette_green (in_bus.palette_green),
    .in_palette_blue  (in_bus.palette_blue),
    .cmd              (cmd),
    .sts              (sts),
    .out_pix          (pix)
  );

  // result word straight from the output register
  assign out_bus.red_level   = pix.red_level;
  assign out_bus.green_level = pix.green_level;
  assign out_bus.blue_level  = pix.blue_level;
  assign out_bus.column      = pix.column;
  assign out_bus.row_end     = pix.row_end;
  assign out_bus.run_end     = pix.run_end;

endmodule

`default_nettype wire

### sv/bpu_chk.sv
// Port-level checker for the bitmap pixel unpacker, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module bpu_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_operation,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_row_end,
  input wire logic out_run_end
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // inside a pixel run no new input is taken
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_end |-> !in_ready)
    else $error("input ready in the middle of a pixel run");

  // last pixel of a row always closes the run
  a_row_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_run_end)
    else $error("row end without run end");

  // palette writes leave the block idle
  a_pal_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == 1'b0) |=> in_ready)
    else $error("palette write left the block busy");

endmodule

bind bitmap_pixel_unpacker bpu_chk u_bpu_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .in_operation (in_bus.operation),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_row_end  (out_bus.row_end),
  .out_run_end  (out_bus.run_end)
);

`default_nettype wire

### sim/bitmap_pixel_unpacker_tb.sv
// Testbench for bitmap_pixel_unpacker: streams palette writes and row data bytes
// across a series of register settings and checks every output pixel word.
// Depends on bpu_pkg, bpu_in_if, bpu_out_if and the unpacker RTL.
`timescale 1ns / 1ps

module bitmap_pixel_unpacker_tb;
  import bpu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 15;
  localparam int DRAIN_WAIT  = 80;   // covers the slowest, mask-path pixel

  // Pixel predictor and the queue of pixel words still to come out.
  class pixel_scoreboard;
    logic [23:0] palette [PALETTE_DEPTH];
    int unsigned depth, width_reg, pal_count;
    logic [31:0] mask_r, mask_g, mask_b;
    int unsigned row_byte, pix_byte;
    logic [31:0] pix_acc;
    pix_t        pending [$];

    function new();
      depth = 24; width_reg = 1; pal_count = 0;
      mask_r = 32'h00FF0000; mask_g = 32'h0000FF00; mask_b = 32'h000000FF;
      row_byte = 0; pix_byte = 0; pix_acc = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_BPP:        depth = 32'(val[5:0]);
        CFG_ROW_WIDTH:  width_reg = 32'(val[12:0]);
        CFG_PAL_COUNT:  pal_count = 32'(val[8:0]);
        CFG_RED_MASK:   mask_r = val;
        CFG_GREEN_MASK: mask_g = val;
        CFG_BLUE_MASK:  mask_b = val;
        default: ;
      endcase
    endfunction

    // mask field scaled to 16 bits, rounded to nearest, saturating
    function logic [15:0] scale_field(logic [31:0] word, logic [31:0] mask);
      int unsigned sh, nb;
      logic [31:0] m;
      longint unsigned v, maxv, lvl;
      if (mask == 0) return 16'd0;
      sh = 0;
      while (sh < 31 && mask[sh] == 1'b0) sh++;
      m = mask >> sh;
      nb = 0;
      while (nb < 32 && m[0]) begin
        nb++;
        m = m >> 1;
      end
      v = (word & mask) >> sh;
      maxv = (64'd1 << nb) - 1;
      lvl = (v * 65535 + maxv / 2) / maxv;
      return (lvl > 65535) ? 16'hFFFF : lvl[15:0];
    endfunction

    function pix_t make_pix(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                            int unsigned col, int unsigned w);
      pix_t p;
      p.red_level = r; p.green_level = g; p.blue_level = b;
      p.column = col[11:0];
      p.row_end = (col + 1 == w);
      p.run_end = 1'b0;
      return p;
    endfunction

    function void note_word(logic op, logic [7:0] data, logic [7:0] idx,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, stride, per, cnt, col, ix, bpb, pos;
      logic [23:0] e;
      logic [31:0] word;
      pix_t run [$];
      if (op == OP_PALETTE) begin
        palette[idx] = {r, g, b};
        return;
      end
      if (!(depth inside {1, 4, 8, 16, 24, 32})) return;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      stride = (w * depth + 31) / 32 * 4;
      if (depth <= 8) begin
        per = 8 / depth;
        cnt = (pal_count == 0) ? (1 << depth) : pal_count;
        if (cnt > PALETTE_DEPTH) cnt = PALETTE_DEPTH;
        for (int k = 0; k < per; k++) begin
          col = row_byte * per + k;
          if (col >= w) break;
          ix = (data >> ((per - 1 - k) * depth)) & ((1 << depth) - 1);
          e = (ix < cnt) ? palette[ix] : 24'h0;
          run.push_back(make_pix(e[23:16] * 16'd257, e[15:8] * 16'd257,
                                 e[7:0] * 16'd257, col, w));
        end
      end else begin
        bpb = depth / 8;
        if (row_byte < w * bpb) begin
          pos = pix_byte & 3;
          if (pos < bpb - 1) begin
            pix_acc = pix_acc | (32'(data) << (8 * pos));
            pix_byte = pos + 1;
          end else begin
            word = (pix_acc & 32'hFFFFFF) | (32'(data) << (8 * pos));
            col = row_byte / bpb;
            if (bpb == 3)
              run.push_back(make_pix(word[23:16] * 16'd257, word[15:8] * 16'd257,
                                     word[7:0] * 16'd257, col, w));
            else
              run.push_back(make_pix(scale_field(word, mask_r), scale_field(word, mask_g),
                                     scale_field(word, mask_b), col, w));
            pix_acc = '0;
            pix_byte = 0;
          end
        end
      end
      row_byte++;
      if (row_byte >= stride) begin
        row_byte = 0; pix_acc = '0; pix_byte = 0;
      end
      if (run.size() > 0) run[run.size() - 1].run_end = 1'b1;
      foreach (run[i]) pending.push_back(run[i]);
    endfunction

    // returns "" on match, else a description of the first bad field
    function string check_pixel(pix_t got);
      pix_t exp_pix;
      if (pending.size() == 0) return $sformatf("unexpected pixel %p", got);
      exp_pix = pending.pop_front();
      if (got.red_level !== exp_pix.red_level)
        return $sformatf("red %h, want %h", got.red_level, exp_pix.red_level);
      if (got.green_level !== exp_pix.green_level)
        return $sformatf("green %h, want %h", got.green_level, exp_pix.green_level);
      if (got.blue_level !== exp_pix.blue_level)
        return $sformatf("blue %h, want %h", got.blue_level, exp_pix.blue_level);
      if (got.column !== exp_pix.column)
        return $sformatf("column %0d, want %0d", got.column, exp_pix.column);
      if (got.row_end !== exp_pix.row_end)
        return $sformatf("row_end %b, want %b", got.row_end, exp_pix.row_end);
      if (got.run_end !== exp_pix.run_end)
        return $sformatf("run_end %b, want %b", got.run_end, exp_pix.run_end);
      return "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_BPP;
  logic [31:0] cfg_data = '0;
  bit          steady = 1'b0;   // no idling on either side while set
  int          err_count = 0;
  int          cycles = 0;

  bpu_in_if  in_bus ();
  bpu_out_if out_bus ();

  pixel_scoreboard sb = new();

  bitmap_pixel_unpacker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Output side: random backpressure, changed on the falling edge.
  initial out_bus.ready = 1'b0;
  always @(negedge clk) begin
    out_bus.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Accepted pixel words are checked against the oldest prediction.
  always @(posedge clk) begin
    string why;
    pix_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.red_level   = out_bus.red_level;
      got.green_level = out_bus.green_level;
      got.blue_level  = out_bus.blue_level;
      got.column      = out_bus.column;
      got.row_end     = out_bus.row_end;
      got.run_end     = out_bus.run_end;
      why = sb.check_pixel(got);
      if (why != "") report(why);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Called on a falling edge; returns on the falling edge after acceptance.
  task automatic send_word(logic op, logic [7:0] data, logic [7:0] idx,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.operation = op;
    in_bus.data_byte = data;
    in_bus.palette_index = idx;
    in_bus.palette_red = r;
    in_bus.palette_green = g;
    in_bus.palette_blue = b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_word(op, data, idx, r, g, b);
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] data);
    send_word(OP_DATA, data, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_palette(logic [7:0] idx, logic [23:0] rgb);
    send_word(OP_PALETTE, 8'($urandom), idx, rgb[23:16], rgb[15:8], rgb[7:0]);
  endtask

  // Block is idle once every pixel is out and the slowest path has drained.
  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One setting: all six registers, then a burst of data bytes with some
  // palette rewrites mixed in. Data leans on 00/FF now and then.
  task automatic run_phase(int bpp, int width, int count, logic [31:0] rm,
                           logic [31:0] gm, logic [31:0] bm, int nbytes,
                           bit quiet, bit hold_mid);
    logic [7:0] d;
    wait_drained();
    cfg_write(CFG_BPP, bpp);
    cfg_write(CFG_ROW_WIDTH, width);
    cfg_write(CFG_PAL_COUNT, count);
    cfg_write(CFG_RED_MASK, rm);
    cfg_write(CFG_GREEN_MASK, gm);
    cfg_write(CFG_BLUE_MASK, bm);
    steady = quiet;
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_palette(8'($urandom), 24'($urandom));
      case ($urandom_range(0, 7))
        0: d = 8'h00;
        1: d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      send_byte(d);
      // sender holds off until every pixel so far has come out
      if (hold_mid && i == nbytes / 2) begin
        in_bus.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.operation = OP_DATA;
    in_bus.data_byte = '0;
    in_bus.palette_index = '0;
    in_bus.palette_red = '0;
    in_bus.palette_green = '0;
    in_bus.palette_blue = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // fill entries 0..31; no palette-mode phase uses a palette count above 32,
    // so no unwritten entry is ever looked up
    send_palette(8'd0, 24'h000000);
    send_palette(8'd31, 24'hFFFFFF);
    for (int i = 1; i < 31; i++) send_palette(8'(i), 24'($urandom));

    // directed: reset settings (24 bpp, width 1) with extreme bytes
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
    send_byte(8'h01); send_byte(8'h55); send_byte(8'hAA);

    run_phase(1, 13, 0, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 16, 0, 0);
    // indices past a short palette come out black
    run_phase(4, 5, 10, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 24, 0, 0);
    // same at 8 bits, most indices land past the count
    run_phase(8, 3, 24, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 24, 0, 0);
    run_phase(24, 2, 0, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 24, 1, 0);
    // 5-5-5 words, with a mid-phase drain
    run_phase(16, 3, 0, 32'h00007C00, 32'h000003E0, 32'h0000001F, 24, 0, 1);
    run_phase(32, 1, 0, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 16, 0, 0);
    // split mask saturates, empty mask is zero, full mask
    run_phase(32, 2, 0, 32'h00F0F000, 32'h00000000, 32'hFFFFFFFF, 24, 0, 0);
    // unsupported depth: bytes vanish
    run_phase(7, 3, 1, 32'h0, 32'h0, 32'h0, 8, 0, 0);
    // width 0 taken as 1
    run_phase(1, 0, 1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 8, 0, 0);
    // width beyond the maximum saturates
    run_phase(8, 8191, 32, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 20, 0, 0);
    run_phase(16, 4096, 511, 32'h0000F800, 32'h000007E0, 32'h00000001, 20, 0, 0);
    run_phase(32, 3, 0, $urandom, $urandom, $urandom, 24, 0, 0);
    run_phase(4, 4095, 0, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 20, 0, 0);

    wait_drained();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
